// ----- hdl/rcs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rcs_pkg
// Shared types and constants for the RIFF/WAVE chunk seeker.
// ----------------------------------------------------------------------------
package rcs_pkg;

    // four-character tags, big-endian packed
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;

    // result status codes
    localparam logic [2:0] ST_SEARCHING = 3'd0;
    localparam logic [2:0] ST_FOUND     = 3'd1;
    localparam logic [2:0] ST_BAD_RIFF  = 3'd2;
    localparam logic [2:0] ST_BAD_WAVE  = 3'd3;
    localparam logic [2:0] ST_TRUNCATED = 3'd4;

    // register map (word index)
    localparam logic REG_TARGET_ID = 1'b0;

    localparam logic [31:0] OFFSET_MAX = 32'hFFFF_FFFF;

    // parser phase, one-hot
    typedef enum logic [6:0] {
        PH_RIFF_TAG   = 7'b000_0001,
        PH_RIFF_SIZE  = 7'b000_0010,
        PH_WAVE_TAG   = 7'b000_0100,
        PH_CHUNK_ID   = 7'b000_1000,
        PH_CHUNK_SIZE = 7'b001_0000,
        PH_SKIP       = 7'b010_0000,
        PH_DONE       = 7'b100_0000
    } phase_t;

endpackage : rcs_pkg
`default_nettype wire

// ----- hdl/riff_chunk_seeker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// riff_chunk_seeker
// Walks a WAV byte stream, checks the RIFF/WAVE header, skips chunk bodies
// (plus the pad byte of odd sizes) and stops at the chunk whose id matches
// the target register. One result beat per input beat.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------
//  in       | sink      | in_valid / in_ready  | data_byte, first_byte,
//           |           |                      | end_of_data
//  out      | source    | out_valid / out_ready| status, bad_fourcc, riff_size,
//           |           |                      | chunk_offset
//  cfg      | APB slave | psel/penable/pready  | target_chunk_id at 0x0
//
//  One beat per cycle unless out stalls: parser state and the result register
//  both load when a beat is accepted; the result appears in the cycle after.
//  A new beat is taken while the result register is empty or being drained.
//  Stalls on out hold the result and lower in_ready.
//  Reset (rst_n low, asynchronous) clears the parser and sets the target
//  id to 'fmt '.
// ----------------------------------------------------------------------------
module riff_chunk_seeker
    import rcs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // input stream
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        first_byte,
    input  wire logic        end_of_data,

    // result stream
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [31:0]      bad_fourcc,
    output logic [31:0]      riff_size,
    output logic [31:0]      chunk_offset,

    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // parser state
    phase_t      phase_reg,          phase_next;
    logic [1:0]  byte_in_field_reg,  byte_in_field_next;
    logic [31:0] id_shift_reg,       id_shift_next;
    logic [31:0] size_accum_reg,     size_accum_next;
    logic [32:0] skip_remaining_reg, skip_remaining_next;
    logic [31:0] byte_offset_reg,    byte_offset_next;
    logic [31:0] master_size_reg,    master_size_next;
    logic [2:0]  final_status_reg,   final_status_next;
    logic [31:0] error_id_reg,       error_id_next;
    logic [31:0] found_offset_reg,   found_offset_next;

    logic [31:0] target_id_reg;

    // result register
    logic        out_valid_reg;
    logic [2:0]  status_reg;
    logic [31:0] bad_fourcc_reg;
    logic [31:0] riff_size_reg;
    logic [31:0] chunk_offset_reg;

    // state after an optional restart, before the byte is taken
    phase_t      cur_phase;
    logic [1:0]  cur_lane;
    logic [31:0] cur_id;
    logic [31:0] cur_size;
    logic [32:0] cur_skip;
    logic [31:0] cur_offset;
    logic [31:0] cur_master;
    logic [2:0]  cur_status;
    logic [31:0] cur_error;
    logic [31:0] cur_found;

    logic [31:0] id_shifted;
    logic [31:0] size_merged;
    logic [32:0] skip_dec;
    logic        last_byte;
    logic        in_beat;
    logic        cfg_write;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_beat   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    assign status       = status_reg;
    assign bad_fourcc   = bad_fourcc_reg;
    assign riff_size    = riff_size_reg;
    assign chunk_offset = chunk_offset_reg;

    // register read
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_TARGET_ID)
        begin
            prdata = target_id_reg;
        end
    end

    // ------------------------------------------------------------------
    // restart clears everything but the target
    // ------------------------------------------------------------------
    always_comb
    begin
        if (first_byte)
        begin
            cur_phase  = PH_RIFF_TAG;
            cur_lane   = '0;
            cur_id     = '0;
            cur_size   = '0;
            cur_skip   = '0;
            cur_offset = '0;
            cur_master = '0;
            cur_status = ST_SEARCHING;
            cur_error  = '0;
            cur_found  = '0;
        end
        else
        begin
            cur_phase  = phase_reg;
            cur_lane   = byte_in_field_reg;
            cur_id     = id_shift_reg;
            cur_size   = size_accum_reg;
            cur_skip   = skip_remaining_reg;
            cur_offset = byte_offset_reg;
            cur_master = master_size_reg;
            cur_status = final_status_reg;
            cur_error  = error_id_reg;
            cur_found  = found_offset_reg;
        end
    end

    // field helpers
    assign last_byte   = (cur_lane == 2'd3);
    assign id_shifted  = {cur_id[23:0], data_byte};
    assign size_merged = cur_size | ({24'd0, data_byte} << {cur_lane, 3'b000});
    assign skip_dec    = (cur_skip != '0) ? (cur_skip - 33'd1) : cur_skip;

    // ------------------------------------------------------------------
    // per-byte parser step
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next          = cur_phase;
        byte_in_field_next  = cur_lane;
        id_shift_next       = cur_id;
        size_accum_next     = cur_size;
        skip_remaining_next = cur_skip;
        byte_offset_next    = cur_offset;
        master_size_next    = cur_master;
        final_status_next   = cur_status;
        error_id_next       = cur_error;
        found_offset_next   = cur_found;

        if (end_of_data)
        begin
            if (cur_status == ST_SEARCHING)
            begin
                final_status_next = ST_TRUNCATED;
                phase_next        = PH_DONE;
            end
        end
        else if (cur_status == ST_SEARCHING)
        begin
            case (cur_phase)
                PH_RIFF_TAG, PH_WAVE_TAG, PH_CHUNK_ID:
                begin
                    if (cur_phase == PH_CHUNK_ID && cur_lane == 2'd0)
                    begin
                        found_offset_next = cur_offset;
                    end
                    id_shift_next      = id_shifted;
                    byte_in_field_next = cur_lane + 2'd1;
                    if (last_byte)
                    begin
                        if (cur_phase == PH_RIFF_TAG)
                        begin
                            if (id_shifted != TAG_RIFF)
                            begin
                                final_status_next = ST_BAD_RIFF;
                                error_id_next     = id_shifted;
                                phase_next        = PH_DONE;
                            end
                            else
                            begin
                                phase_next      = PH_RIFF_SIZE;
                                size_accum_next = '0;
                            end
                        end
                        else if (cur_phase == PH_WAVE_TAG)
                        begin
                            if (id_shifted != TAG_WAVE)
                            begin
                                final_status_next = ST_BAD_WAVE;
                                error_id_next     = id_shifted;
                                phase_next        = PH_DONE;
                            end
                            else
                            begin
                                phase_next = PH_CHUNK_ID;
                            end
                        end
                        else if (id_shifted == target_id_reg)
                        begin
                            final_status_next = ST_FOUND;
                            phase_next        = PH_DONE;
                        end
                        else
                        begin
                            phase_next      = PH_CHUNK_SIZE;
                            size_accum_next = '0;
                        end
                    end
                end
                PH_RIFF_SIZE, PH_CHUNK_SIZE:
                begin
                    size_accum_next    = size_merged;
                    byte_in_field_next = cur_lane + 2'd1;
                    if (last_byte)
                    begin
                        if (cur_phase == PH_RIFF_SIZE)
                        begin
                            master_size_next = size_merged;
                            phase_next       = PH_WAVE_TAG;
                        end
                        else
                        begin
                            // body length plus pad byte on odd sizes
                            skip_remaining_next = {1'b0, size_merged}
                                                + {32'd0, size_merged[0]};
                            phase_next = (size_merged == '0) ? PH_CHUNK_ID : PH_SKIP;
                        end
                    end
                end
                PH_SKIP:
                begin
                    skip_remaining_next = skip_dec;
                    if (skip_dec == '0)
                    begin
                        phase_next = PH_CHUNK_ID;
                    end
                end
                default:
                begin
                end
            endcase

            // saturating file offset
            if (cur_offset != OFFSET_MAX)
            begin
                byte_offset_next = cur_offset + 32'd1;
            end
        end
    end

    // ------------------------------------------------------------------
    // state, result and config registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_RIFF_TAG;
            byte_in_field_reg  <= '0;
            id_shift_reg       <= '0;
            size_accum_reg     <= '0;
            skip_remaining_reg <= '0;
            byte_offset_reg    <= '0;
            master_size_reg    <= '0;
            final_status_reg   <= ST_SEARCHING;
            error_id_reg       <= '0;
            found_offset_reg   <= '0;
            target_id_reg      <= TAG_FMT;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write && paddr[2] == REG_TARGET_ID)
            begin
                target_id_reg <= pwdata;
            end

            if (in_beat)
            begin
                phase_reg          <= phase_next;
                byte_in_field_reg  <= byte_in_field_next;
                id_shift_reg       <= id_shift_next;
                size_accum_reg     <= size_accum_next;
                skip_remaining_reg <= skip_remaining_next;
                byte_offset_reg    <= byte_offset_next;
                master_size_reg    <= master_size_next;
                final_status_reg   <= final_status_next;
                error_id_reg       <= error_id_next;
                found_offset_reg   <= found_offset_next;
                out_valid_reg      <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            status_reg     <= final_status_next;
            bad_fourcc_reg <= (final_status_next == ST_BAD_RIFF ||
                               final_status_next == ST_BAD_WAVE) ? error_id_next : '0;
            riff_size_reg  <= master_size_next;
            chunk_offset_reg <= (final_status_next == ST_FOUND) ? found_offset_next : '0;
        end
    end

endmodule : riff_chunk_seeker
`default_nettype wire

// ----- tb/riff_chunk_seeker_checker.sv -----
// ----------------------------------------------------------------------------
// riff_chunk_seeker_checker
// Passive monitor for the chunk seeker: follows the target id register on
// the APB port, runs its own RIFF/WAVE parser on every accepted input beat
// and compares each result beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module riff_chunk_seeker_checker
    import rcs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        first_byte,
    input  wire logic        end_of_data,

    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [2:0]  status,
    input  wire logic [31:0] bad_fourcc,
    input  wire logic [31:0] riff_size,
    input  wire logic [31:0] chunk_offset,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,

    output int               mismatches,
    output int               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] bad_fourcc;
        logic [31:0] riff_size;
        logic [31:0] chunk_offset;
    } seek_result_t;

    // shadow of the target register and of the parser
    logic [31:0]  target_id = TAG_FMT;
    phase_t       phase;
    logic [1:0]   field_byte;
    logic [31:0]  fourcc_shift;
    logic [31:0]  size_acc;
    logic [32:0]  body_left;
    logic [31:0]  file_pos;
    logic [31:0]  master_len;
    logic [2:0]   verdict;
    logic [31:0]  bad_id;
    logic [31:0]  hit_pos;

    seek_result_t expected_q[$];
    int           fail_total = 0;
    int           expected_count = 0;

    assign mismatches  = fail_total;
    assign outstanding = expected_count;

    task automatic restart_parse();
        phase        = PH_RIFF_TAG;
        field_byte   = '0;
        fourcc_shift = '0;
        size_acc     = '0;
        body_left    = '0;
        file_pos     = '0;
        master_len   = '0;
        verdict      = ST_SEARCHING;
        bad_id       = '0;
        hit_pos      = '0;
    endtask

    // one data byte while still searching
    task automatic advance_byte(input logic [7:0] b);
        logic last;
        last = (field_byte == 2'd3);
        case (phase)
            PH_RIFF_TAG, PH_WAVE_TAG, PH_CHUNK_ID:
            begin
                // chunk offset is where the id starts
                if (phase == PH_CHUNK_ID && field_byte == 2'd0)
                    hit_pos = file_pos;
                fourcc_shift = {fourcc_shift[23:0], b};
                field_byte   = field_byte + 2'd1;
                if (last)
                begin
                    if (phase == PH_RIFF_TAG)
                    begin
                        if (fourcc_shift != TAG_RIFF)
                        begin
                            verdict = ST_BAD_RIFF;
                            bad_id  = fourcc_shift;
                            phase   = PH_DONE;
                        end
                        else
                        begin
                            phase    = PH_RIFF_SIZE;
                            size_acc = '0;
                        end
                    end
                    else if (phase == PH_WAVE_TAG)
                    begin
                        if (fourcc_shift != TAG_WAVE)
                        begin
                            verdict = ST_BAD_WAVE;
                            bad_id  = fourcc_shift;
                            phase   = PH_DONE;
                        end
                        else
                            phase = PH_CHUNK_ID;
                    end
                    else if (fourcc_shift == target_id)
                    begin
                        verdict = ST_FOUND;
                        phase   = PH_DONE;
                    end
                    else
                    begin
                        phase    = PH_CHUNK_SIZE;
                        size_acc = '0;
                    end
                end
            end
            PH_RIFF_SIZE, PH_CHUNK_SIZE:
            begin
                // sizes are little-endian
                size_acc   = size_acc | (32'(b) << {field_byte, 3'b000});
                field_byte = field_byte + 2'd1;
                if (last)
                begin
                    if (phase == PH_RIFF_SIZE)
                    begin
                        master_len = size_acc;
                        phase      = PH_WAVE_TAG;
                    end
                    else
                    begin
                        // body plus pad byte on odd sizes
                        body_left = {1'b0, size_acc} + 33'(size_acc[0]);
                        if (body_left == '0)
                            phase = PH_CHUNK_ID;
                        else
                            phase = PH_SKIP;
                    end
                end
            end
            PH_SKIP:
            begin
                if (body_left != '0)
                    body_left = body_left - 33'd1;
                if (body_left == '0)
                    phase = PH_CHUNK_ID;
            end
            default: ;
        endcase
        if (file_pos != OFFSET_MAX)
            file_pos = file_pos + 32'd1;
    endtask

    task automatic predict_beat(input logic [7:0] b, input logic restart, input logic eod);
        seek_result_t r;
        if (restart)
            restart_parse();
        if (eod)
        begin
            if (verdict == ST_SEARCHING)
            begin
                verdict = ST_TRUNCATED;
                phase   = PH_DONE;
            end
        end
        else if (verdict == ST_SEARCHING)
            advance_byte(b);

        r.status       = verdict;
        r.bad_fourcc   = (verdict == ST_BAD_RIFF || verdict == ST_BAD_WAVE) ? bad_id : '0;
        r.riff_size    = master_len;
        r.chunk_offset = (verdict == ST_FOUND) ? hit_pos : '0;
        expected_q.push_back(r);
    endtask

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_total++;
        end
    endfunction

    task automatic check_result();
        seek_result_t want;
        if (expected_q.size() == 0)
        begin
            $error("result beat with nothing expected (status %0d)", status);
            fail_total++;
        end
        else
        begin
            want = expected_q.pop_front();
            compare_field("status", 32'(want.status), 32'(status));
            compare_field("bad_fourcc", want.bad_fourcc, bad_fourcc);
            compare_field("riff_size", want.riff_size, riff_size);
            compare_field("chunk_offset", want.chunk_offset, chunk_offset);
        end
    endtask

    // all channels sampled at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_id = TAG_FMT;
            restart_parse();
            expected_q.delete();
            expected_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && (paddr >> 2) == 3'(REG_TARGET_ID))
                target_id = pwdata;
            if (in_valid && in_ready)
                predict_beat(data_byte, first_byte, end_of_data);
            if (out_valid && out_ready)
                check_result();
            expected_count = expected_q.size();
        end
    end

endmodule : riff_chunk_seeker_checker

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the chunk seeker: a short directed run over a bad
// RIFF tag, restart and end of stream, then random WAV files, broken
// headers and noise under several target ids, with random idling on both
// channels, one long output stall and idle pauses between phases.
// ----------------------------------------------------------------------------
module testbench
    import rcs_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_STALL   = 100;
    localparam int DRAIN_CYCLES = 10;
    localparam int PHASES       = 5;
    localparam int PHASE_BEATS  = 140;

    typedef struct packed {
        logic [7:0] b;
        logic       first;
        logic       eod;
    } byte_beat_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte   = '0;
    logic        first_byte  = 1'b0;
    logic        end_of_data = 1'b0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [2:0]  status;
    logic [31:0] bad_fourcc;
    logic [31:0] riff_size;
    logic [31:0] chunk_offset;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    int          mismatches;
    int          outstanding;

    byte_beat_t  file_q[$];
    logic [31:0] target_now = TAG_FMT;
    bit          quiet      = 1'b0;
    bit          stall_long = 1'b0;

    always #(CLK_HALF) clk = ~clk;

    riff_chunk_seeker DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .first_byte   (first_byte),
        .end_of_data  (end_of_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .bad_fourcc   (bad_fourcc),
        .riff_size    (riff_size),
        .chunk_offset (chunk_offset),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    riff_chunk_seeker_checker seek_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .first_byte   (first_byte),
        .end_of_data  (end_of_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .bad_fourcc   (bad_fourcc),
        .riff_size    (riff_size),
        .chunk_offset (chunk_offset),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    // watchdog
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("testbench NOT OK");
        $finish;
    end

    // result side: random stall bursts, one long hold-off on request
    always
    begin
        @(negedge clk);
        if (stall_long)
        begin
            out_ready <= 1'b0;
            repeat (LONG_STALL) @(negedge clk);
            stall_long = 1'b0;
            out_ready <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            out_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
            out_ready <= 1'b1;
        end
        else
            out_ready <= 1'b1;
    end

    function automatic void put_beat(input logic [7:0] b, input logic first, input logic eod);
        byte_beat_t beat;
        beat.b     = b;
        beat.first = first;
        beat.eod   = eod;
        file_q.push_back(beat);
    endfunction

    // tags go out big-endian, sizes little-endian
    function automatic void put_word(input logic [31:0] w, input bit big_endian);
        for (int i = 0; i < 4; i++)
            put_beat(big_endian ? w[31 - 8*i -: 8] : w[8*i +: 8], 1'b0, 1'b0);
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_beat(input logic [7:0] b, input logic first, input logic eod);
        data_byte   <= b;
        first_byte  <= first;
        end_of_data <= eod;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
    endtask

    task automatic send_file(output int n);
        n = file_q.size();
        foreach (file_q[i])
            send_beat(file_q[i].b, file_q[i].first, file_q[i].eod);
        file_q.delete();
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_idle();
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // well-formed header and chunk list; ends on the target, an end of
    // stream, a cut, or in the middle of a huge chunk
    task automatic make_wave_file(input logic [31:0] want_id);
        int          n_chunks;
        int          ending;
        int          cut;
        logic [31:0] csize;
        logic [31:0] cid;
        bit          huge;
        put_word(TAG_RIFF, 1'b1);
        put_word($urandom(), 1'b0);
        put_word(TAG_WAVE, 1'b1);
        huge     = 1'b0;
        n_chunks = $urandom_range(0, 4);
        for (int c = 0; c < n_chunks && !huge; c++)
        begin
            if ($urandom_range(0, 1) == 0)
                cid = {8'($urandom_range(32, 126)), 8'($urandom_range(32, 126)),
                       8'($urandom_range(32, 126)), 8'($urandom_range(32, 126))};
            else
                cid = $urandom();
            if ($urandom_range(0, 24) == 0)
            begin
                huge  = 1'b1;
                csize = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : $urandom();
            end
            else if ($urandom_range(0, 3) == 0)
                csize = '0;
            else
                csize = $urandom_range(1, 12);
            put_word(cid, 1'b1);
            put_word(csize, 1'b0);
            if (huge)
                repeat ($urandom_range(0, 6)) put_beat(8'($urandom()), 1'b0, 1'b0);
            else
                repeat (csize + csize[0]) put_beat(8'($urandom()), 1'b0, 1'b0);
        end
        if (!huge)
        begin
            ending = $urandom_range(0, 9);
            if (ending < 6)
                put_word(want_id, 1'b1);
            else if (ending < 8)
                put_beat(8'($urandom()), 1'b0, 1'b1);
            else
            begin
                cut    = $urandom_range(0, file_q.size() - 1);
                file_q = file_q[0:cut];
                put_beat(8'($urandom()), 1'b0, 1'b1);
            end
        end
        file_q[0].first = 1'b1;
    endtask

    initial
    begin
        int          n;
        int          sent;
        int          kind;
        int          flip;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // bad RIFF tag with a zero byte, then an ignored byte and end
        put_word(32'h0049_4646, 1'b1);
        file_q[0].first = 1'b1;
        put_beat(8'hFF, 1'b0, 1'b0);
        put_beat(8'h00, 1'b0, 1'b1);
        send_file(n);
        // end together with restart
        put_beat(8'hA5, 1'b1, 1'b1);
        send_file(n);
        // largest master size, target found right after the header
        put_word(TAG_RIFF, 1'b1);
        put_word(OFFSET_MAX, 1'b0);
        put_word(TAG_WAVE, 1'b1);
        put_word(TAG_FMT, 1'b1);
        put_beat(8'h3C, 1'b0, 1'b1);
        file_q[0].first = 1'b1;
        send_file(n);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            // target changes only with both channels empty
            in_valid <= 1'b0;
            wait_idle();
            case (ph)
                0: target_now = TAG_FMT;
                1: target_now = 32'h0000_0000;
                2: target_now = 32'hFFFF_FFFF;
                3: target_now = 32'h6461_7461;
                default: target_now = $urandom();
            endcase
            write_reg(3'(REG_TARGET_ID) << 2, target_now);
            // a register index past the map is dropped
            if (ph == 1)
                write_reg(3'd4, ~target_now);
            if (ph == 2)
                stall_long = 1'b1;
            if (ph == PHASES - 1)
                quiet = 1'b1;

            sent = 0;
            while (sent < PHASE_BEATS)
            begin
                kind = $urandom_range(0, 19);
                if (kind < 14)
                    make_wave_file(target_now);
                else if (kind < 17)
                begin
                    // header with one flipped bit in a tag
                    put_word(TAG_RIFF, 1'b1);
                    put_word($urandom(), 1'b0);
                    put_word(TAG_WAVE, 1'b1);
                    flip = (($urandom_range(0, 1) == 0) ? 0 : 8) + $urandom_range(0, 3);
                    file_q[flip].b = file_q[flip].b ^ (8'd1 << $urandom_range(0, 7));
                    file_q[0].first = 1'b1;
                end
                else
                    repeat ($urandom_range(4, 12))
                        put_beat(8'($urandom()), $urandom_range(0, 7) == 0,
                                 $urandom_range(0, 15) == 0);
                send_file(n);
                sent += n;
                // trailing beats, mostly ignored after a final status
                if ($urandom_range(0, 1) == 0)
                begin
                    repeat ($urandom_range(1, 3))
                        put_beat(8'($urandom()), 1'b0, $urandom_range(0, 3) == 0);
                    send_file(n);
                end
            end
        end

        in_valid <= 1'b0;
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule : testbench
